// File: src/itbd_pkg.sv
// Shared widths, register codes and the symbol lookup for the base-digit converter.
`default_nettype none
package itbd_pkg;
	localparam int MagW        = 64;
	localparam int RadixW      = 5;
	localparam int DigitW      = 4;
	localparam int SymW        = 8;
	localparam int MaxRadix    = 16;
	localparam int MinRadix    = 2;
	localparam int MaxDigits   = 64;
	localparam int IdxW        = $clog2(MaxDigits);
	localparam int BitsPerStep = 4;
	localparam int DivSteps    = MagW / BitsPerStep;
	localparam int StepW       = $clog2(DivSteps);
	localparam int CfgIdxW     = 2;
	localparam int CfgDataW    = 64;
	localparam int RadixReset  = 10;

	typedef enum logic [CfgIdxW-1:0] {
		REG_RADIX  = 2'd0,
		REG_SYM_LO = 2'd1,
		REG_SYM_HI = 2'd2
	} cfg_reg_t;

	function automatic logic [SymW-1:0] symbol_of(input logic [CfgDataW-1:0] lo,
	                                              input logic [CfgDataW-1:0] hi,
	                                              input logic [DigitW-1:0] digit);
		logic [2*CfgDataW-1:0] tab;
		tab = {hi, lo};
		return tab[digit*SymW +: SymW];
	endfunction
endpackage
`default_nettype wire

// File: src/itbd_in_if.sv
// Input request channel: one signed value per request.
`default_nettype none
interface itbd_in_if import itbd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [MagW-1:0] value;

	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);
endinterface
`default_nettype wire

// File: src/itbd_out_if.sv
// Output request channel: one digit symbol per request.
`default_nettype none
interface itbd_out_if import itbd_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [SymW-1:0] symbol;
	logic            negative;
	logic            last;

	modport source (output valid, symbol, negative, last, input ready);
	modport sink (input valid, symbol, negative, last, output ready);
endinterface
`default_nettype wire

// File: src/itbd_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none
interface itbd_cfg_if import itbd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/itbd_div.sv
// Iterative unsigned divider: 64-bit dividend by a small radix, four quotient bits per cycle.
`default_nettype none
module itbd_div import itbd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MagW-1:0]   dividend,
	input  wire logic [RadixW-1:0] divisor,
	output logic                   done,
	output logic [MagW-1:0]        quotient,
	output logic [DigitW-1:0]      remainder
);
	logic [MagW-1:0]   quo_q;
	logic [DigitW-1:0] rem_q;
	logic [StepW-1:0]  step_q;
	logic              busy_q;
	logic              done_q;
	logic [RadixW-1:0] div_q;
	logic [MagW-1:0]   quo_nxt;
	logic [DigitW-1:0] rem_nxt;

	// Restoring division, one bit per inner step; remainder stays below the divisor.
	always_comb begin
		logic [DigitW:0]   t;
		logic [DigitW:0]   diff;
		logic [MagW-1:0]   w;
		logic [DigitW-1:0] r;
		w = quo_q;
		r = rem_q;
		for (int i = 0; i < BitsPerStep; i++) begin
			t    = {r, w[MagW-1]};
			w    = {w[MagW-2:0], 1'b0};
			diff = t - div_q;
			if (t >= div_q) begin
				r    = diff[DigitW-1:0];
				w[0] = 1'b1;
			end else begin
				r = t[DigitW-1:0];
			end
		end
		quo_nxt = w;
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= RadixW'(MinRadix);
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				div_q  <= divisor;
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q  <= quo_nxt;
				rem_q  <= rem_nxt;
				step_q <= step_q + 1'b1;
				if (step_q == StepW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

`ifndef SYNTHESIS
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, remainder} < div_q))
		else $error("divider remainder not below divisor");
`endif
endmodule
`default_nettype wire

// File: src/integer_to_base_digits.sv
// Converts a signed 64-bit value to digit symbols in a radix of 2..16, most significant first.
// Each digit comes from the shared divider (start, then 16 four-bit steps, then done);
// the digits are then read back from the store and looked up as symbols.
// No new value is taken until the last digit sits in the output register.
// Reset: arst_n clears the control state and config registers (radix 10, symbols 0).
`default_nettype none
module integer_to_base_digits import itbd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	itbd_cfg_if.sink  cfg,
	itbd_in_if.sink   din,
	itbd_out_if.source dout
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_BUSY,
		S_RD,
		S_LD
	} state_t;

	state_t            state_q;
	logic [RadixW-1:0] cfg_radix_q;
	logic [CfgDataW-1:0] sym_lo_q;
	logic [CfgDataW-1:0] sym_hi_q;
	logic [RadixW-1:0] radix_q;
	logic [MagW-1:0]   mag_q;
	logic              neg_q;
	logic [IdxW-1:0]   cnt_q;
	logic [IdxW-1:0]   idx_q;
	logic [DigitW-1:0] rd_digit_q;
	logic [DigitW-1:0] digit_mem [MaxDigits];
	logic              out_valid_q;
	logic [SymW-1:0]   out_sym_q;
	logic              out_neg_q;
	logic              out_last_q;

	logic              div_start;
	logic              div_done;
	logic [MagW-1:0]   div_quo;
	logic [DigitW-1:0] div_rem;
	logic [RadixW-1:0] eff_radix;
	logic [MagW-1:0]   in_mag;
	logic              ld_ok;

	// Saturate the configured radix into the supported range.
	always_comb begin
		priority if (cfg_radix_q < RadixW'(MinRadix)) eff_radix = RadixW'(MinRadix);
		else if (cfg_radix_q > RadixW'(MaxRadix)) eff_radix = RadixW'(MaxRadix);
		else eff_radix = cfg_radix_q;
	end

	assign in_mag    = din.value[MagW-1] ? (MagW'(0) - MagW'(din.value)) : MagW'(din.value);
	assign div_start = (state_q == S_START);
	assign ld_ok     = !out_valid_q || dout.ready;

	assign cfg.ready     = 1'b1;
	assign din.ready     = (state_q == S_IDLE);
	assign dout.valid    = out_valid_q;
	assign dout.symbol   = out_sym_q;
	assign dout.negative = out_neg_q;
	assign dout.last     = out_last_q;

	itbd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (mag_q),
		.divisor   (radix_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_radix_q <= RadixW'(RadixReset);
			sym_lo_q    <= '0;
			sym_hi_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_RADIX:  cfg_radix_q <= cfg.data[RadixW-1:0];
				REG_SYM_LO: sym_lo_q    <= cfg.data;
				REG_SYM_HI: sym_hi_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Digit store: written once per digit, read back in reverse order.
	always_ff @(posedge clk) begin
		if (state_q == S_BUSY && div_done) digit_mem[cnt_q] <= div_rem;
		if (state_q == S_RD) rd_digit_q <= digit_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			radix_q     <= RadixW'(RadixReset);
			mag_q       <= '0;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_sym_q   <= '0;
			out_neg_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			// drop the output once taken; a load below overrides
			if (dout.valid && dout.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (din.valid) begin
						mag_q   <= in_mag;
						neg_q   <= din.value[MagW-1];
						radix_q <= eff_radix;
						cnt_q   <= '0;
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_BUSY;
				S_BUSY: begin
					if (div_done) begin
						mag_q <= div_quo;
						if (div_quo == '0 || cnt_q == IdxW'(MaxDigits - 1)) begin
							idx_q   <= cnt_q;
							state_q <= S_RD;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_START;
						end
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					// hold until the output register frees up
					if (ld_ok) begin
						out_valid_q <= 1'b1;
						out_sym_q   <= symbol_of(sym_lo_q, sym_hi_q, rd_digit_q);
						out_neg_q   <= neg_q;
						out_last_q  <= (idx_q == '0);
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_BUSY))
		else $error("divider finished outside the divide phase");

	a_digit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUSY && div_done && cnt_q == IdxW'(MaxDigits - 1)) |=> (state_q == S_RD))
		else $error("digit count ran past the store depth");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LD && ld_ok && idx_q == '0) |=>
			(dout.valid && dout.last && state_q == S_IDLE))
		else $error("final digit did not close the run");
`endif
endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for integer_to_base_digits: directed and random conversions across radix settings.
module tb import itbd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
	localparam logic signed [MagW-1:0] MinVal = {1'b1, {(MagW-1){1'b0}}};
	localparam logic signed [MagW-1:0] MaxVal = {1'b0, {(MagW-1){1'b1}}};
	// ASCII "0123456789abcdef", digit k in byte k
	localparam logic [CfgDataW-1:0] HexLo = 64'h3736_3534_3332_3130;
	localparam logic [CfgDataW-1:0] HexHi = 64'h6665_6463_6261_3938;
	localparam int SettleCycles = 8;
	localparam int TailCycles   = 100;
	localparam int MaxPrinted   = 40;

	typedef struct packed {
		logic [SymW-1:0] symbol;
		logic            negative;
		logic            last;
	} digit_sym_t;

	logic clk = 1'b0;
	logic arst_n;

	itbd_cfg_if cfg_bus ();
	itbd_in_if  in_bus ();
	itbd_out_if out_bus ();

	integer_to_base_digits i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.din    (in_bus),
		.dout   (out_bus)
	);

	always #10 clk = ~clk;

	// local copy of the configuration registers
	logic [RadixW-1:0]   radix_reg  = RadixW'(RadixReset);
	logic [CfgDataW-1:0] sym_lo_reg = '0;
	logic [CfgDataW-1:0] sym_hi_reg = '0;

	digit_sym_t  pending_digits[$];
	int unsigned errors         = 0;
	int unsigned values_sent    = 0;
	int unsigned digits_checked = 0;
	int unsigned burst_left     = 0;
	logic [31:0] radix_seen     = '0;

	task automatic report_mismatch(input string what, input logic [63:0] want,
	                               input logic [63:0] got);
		errors++;
		if (errors <= MaxPrinted)
			$display("tb: %s mismatch, expected %0h got %0h at %0t", what, want, got, $time);
	endtask

	function automatic logic [MagW-1:0] eff_radix();
		if (radix_reg < MinRadix) return MagW'(MinRadix);
		if (radix_reg > MaxRadix) return MagW'(MaxRadix);
		return MagW'(radix_reg);
	endfunction

	function automatic logic [SymW-1:0] digit_symbol(input logic [DigitW-1:0] d);
		logic [CfgDataW-1:0] word;
		word = d[3] ? sym_hi_reg : sym_lo_reg;
		return SymW'(word >> (8 * d[2:0]));
	endfunction

	// Divide out the digits, then queue their symbols most significant first.
	function automatic void predict_digits(input logic signed [MagW-1:0] v);
		logic [MagW-1:0]   mag;
		logic [MagW-1:0]   base;
		logic              neg;
		logic [DigitW-1:0] digits[$];
		digit_sym_t        ds;
		neg  = v[MagW-1];
		mag  = neg ? (~v + 1'b1) : v;
		base = eff_radix();
		do begin
			digits.push_front(DigitW'(mag % base));
			mag = mag / base;
		end while (mag != 0);
		foreach (digits[k]) begin
			ds.symbol   = digit_symbol(digits[k]);
			ds.negative = neg;
			ds.last     = (k == digits.size() - 1);
			pending_digits.push_back(ds);
		end
	endfunction

	function automatic logic signed [MagW-1:0] pick_value();
		logic [MagW-1:0] mag;
		logic [MagW-1:0] p;
		logic [MagW-1:0] base;
		int unsigned     nb;
		base = eff_radix();
		case ($urandom_range(0, 9))
			0, 1, 2: return {$urandom, $urandom};
			3, 4, 5: begin
				nb  = $urandom_range(0, 63);
				mag = {$urandom, $urandom} & ((64'd1 << nb) - 1);
			end
			6, 7, 8: begin
				// land next to a power of the radix, where the digit count changes
				p  = 64'd1;
				nb = $urandom_range(0, 63);
				repeat (nb) if (p <= {MagW{1'b1}} / base) p = p * base;
				mag = p + $urandom_range(0, 2) - 1;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: return MinVal;
					1: return MaxVal;
					2: mag = '0;
					default: mag = 64'd1;
				endcase
			end
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	task automatic send_value(input logic signed [MagW-1:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_bus.valid <= 1'b1;
		in_bus.value <= v;
		do @(posedge clk); while (!in_bus.ready);
		predict_digits(v);
		values_sent++;
	endtask

	// Drop the request line and hold until every queued digit has come out.
	task automatic wait_drain();
		in_bus.valid <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			REG_RADIX:  radix_reg  = data[RadixW-1:0];
			REG_SYM_LO: sym_lo_reg = data;
			REG_SYM_HI: sym_hi_reg = data;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [RadixW-1:0] base, input logic [CfgDataW-1:0] lo,
	                         input logic [CfgDataW-1:0] hi);
		logic [CfgDataW-1:0] junk;
		wait_drain();
		junk = {$urandom, $urandom};
		// upper bits of the radix write must be ignored
		write_reg(REG_RADIX, {junk[CfgDataW-1:RadixW], base});
		write_reg(REG_SYM_LO, lo);
		if ($urandom_range(0, 1)) write_reg(REG_UNUSED, ~junk);
		write_reg(REG_SYM_HI, hi);
		cfg_bus.valid <= 1'b0;
		radix_seen[base] = 1'b1;
	endtask

	task automatic test_reset_state();
		send_value('0);
		send_value(64'sd12345);
		send_value(MinVal);
	endtask

	task automatic test_hex_extremes();
		configure(5'd16, HexLo, HexHi);
		send_value('0);
		send_value(64'sd1);
		send_value(-64'sd1);
		send_value(MaxVal);
		send_value(MinVal);
		send_value(64'sh0123_4567_89ab_cdef);
		send_value(-64'sh0123_4567_89ab_cdef);
		send_value(64'sd15);
		send_value(64'sd16);
	endtask

	task automatic test_radix_saturation();
		configure(5'd0, HexLo, HexHi);
		send_value(MinVal);
		configure(5'd1, HexLo, HexHi);
		send_value(MaxVal);
		configure(5'd17, HexLo, HexHi);
		send_value(-64'sd1);
		configure(5'd31, HexLo, HexHi);
		send_value(MinVal);
		configure(5'd2, HexLo, HexHi);
		send_value(MaxVal);
		configure(5'd3, HexLo, HexHi);
		send_value(-64'sd1);
	endtask

	task automatic test_ignored_index();
		configure(5'd10, HexLo, HexHi);
		send_value(64'sd42);
		wait_drain();
		write_reg(REG_UNUSED, '1);
		cfg_bus.valid <= 1'b0;
		send_value(-64'sd9876543210);
		send_value(64'sd7);
	endtask

	task automatic test_random_runs();
		logic [RadixW-1:0] base;
		int unsigned       pause_at;
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0)
				base = RadixW'(MinRadix);
			else if (ph == 1)
				base = RadixW'(MaxRadix);
			else if ($urandom_range(0, 3) == 0)
				base = RadixW'($urandom_range(0, 31));
			else
				base = RadixW'($urandom_range(2, 16));
			configure(base, {$urandom, $urandom}, {$urandom, $urandom});
			pause_at = $urandom_range(5, 45);
			for (int n = 0; n < 50; n++) begin
				if (n == pause_at) wait_drain();
				send_value(pick_value());
			end
		end
	endtask

	// Result check and receiver stall pattern.
	logic [15:0] stall_pattern = '1;
	int unsigned pattern_left  = 0;

	always @(posedge clk) begin : digit_checker
		digit_sym_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			digits_checked++;
			if (pending_digits.size() == 0) begin
				report_mismatch("unrequested digit", '0, out_bus.symbol);
			end else begin
				want = pending_digits.pop_front();
				if (out_bus.symbol !== want.symbol)
					report_mismatch("symbol", want.symbol, out_bus.symbol);
				if (out_bus.negative !== want.negative)
					report_mismatch("negative", want.negative, out_bus.negative);
				if (out_bus.last !== want.last)
					report_mismatch("last", want.last, out_bus.last);
			end
		end
		if (pattern_left == 0) begin
			pattern_left  = $urandom_range(32, 256);
			stall_pattern = ($urandom_range(0, 3) == 0) ? '1 : 16'($urandom);
			if (stall_pattern == '0) stall_pattern = 16'h0001;
		end else begin
			pattern_left--;
		end
		out_bus.ready <= stall_pattern[0];
		stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
	end

	initial begin
		in_bus.valid  = 1'b0;
		in_bus.value  = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_RADIX;
		cfg_bus.data  = '0;
		out_bus.ready = 1'b0;
		arst_n        = 1'b0;
		radix_seen[RadixReset] = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_hex_extremes();
		test_radix_saturation();
		test_ignored_index();
		test_random_runs();

		wait_drain();
		repeat (TailCycles) @(posedge clk);
		$display("tb: %0d values converted, %0d digit symbols checked", values_sent,
		         digits_checked);
		$display("tb: %0d of 32 radix codes used, out-of-range codes saturating",
		         $countones(radix_seen));
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("tb: timeout with %0d digits outstanding", pending_digits.size());
		$display("tb: done, errors");
		$finish;
	end
endmodule
